@@ src/qau_pkg.sv @@
package qau_pkg;

	localparam int DataWidth = 32;
	localparam int FracBits = 28;
	localparam int ProdWidth = 2 * DataWidth;
	localparam int SumWidth = ProdWidth + 3;

	typedef logic signed [DataWidth-1:0] word_t;
	typedef logic signed [ProdWidth-1:0] prod_t;
	typedef logic signed [SumWidth-1:0] sum_t;

	typedef enum logic [1:0] {
		MODE_PRODUCT = 2'd0,
		MODE_CONJ = 2'd1,
		MODE_ROTATE = 2'd2,
		MODE_MATRIX = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t mode;
		word_t a_s;
		word_t a_x;
		word_t a_y;
		word_t a_z;
		word_t b_s;
		word_t b_x;
		word_t b_y;
		word_t b_z;
	} item_t;

	typedef struct packed {
		word_t [8:0] r;
		logic overflow;
	} result_t;

	localparam sum_t Half = sum_t'(1) <<< (FracBits - 1);
	localparam sum_t MaxW = sum_t'({1'b0, {(DataWidth-1){1'b1}}});
	localparam sum_t MinW = -MaxW - sum_t'(1);

	function automatic logic [DataWidth:0] round_sat(input sum_t v);
		sum_t s;
		s = (v + Half) >>> FracBits;
		if (s > MaxW) return {1'b1, MaxW[DataWidth-1:0]};
		if (s < MinW) return {1'b1, MinW[DataWidth-1:0]};
		return {1'b0, s[DataWidth-1:0]};
	endfunction

	function automatic sum_t sx(input prod_t p);
		return sum_t'(p);
	endfunction

endpackage

@@ src/qau_front.sv @@
module qau_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input qau_pkg::item_t in_item,
	output logic q_valid,
	input logic q_stall,
	output qau_pkg::item_t q_item
);

	qau_pkg::item_t mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic push;
	logic pop;

	assign in_stall = (cnt_q == 3'd4);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 3'd0);
	assign pop = q_valid && !q_stall;
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 3'd4 && !pop) |=> in_stall)
		else $error("full queue accepted");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 3'd0) |-> !pop)
		else $error("pop from empty queue");

endmodule

@@ src/qau_back.sv @@
module qau_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_stall,
	input qau_pkg::item_t q_item,
	output logic out_valid,
	input logic out_stall,
	output qau_pkg::result_t out_res
);

	// Stage 1 forms products of a with b or a; stage 2 sums and rounds them
	// (this is the rotation intermediate t; conjugate mode negates a instead); stage 3 forms t*conj(a);
	// stage 4 sums and rounds the rotated values, and passes the other modes' values through.
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;
	qau_pkg::mode_t m_s1, m_s2, m_s3;
	qau_pkg::word_t [3:0] a_s1, a_s2;
	qau_pkg::prod_t [15:0] p_s1;
	qau_pkg::word_t [8:0] w_s2;
	logic ov_s2, ov_s3;
	qau_pkg::prod_t [15:0] p_s3;
	qau_pkg::word_t [8:0] w_s3;
	qau_pkg::result_t res_s4;

	qau_pkg::word_t [3:0] qa, qb, qm;
	qau_pkg::sum_t [8:0] sum2;
	qau_pkg::sum_t [3:0] sum4;
	logic [qau_pkg::DataWidth:0] rs;
	qau_pkg::word_t [8:0] w2n;
	logic ov2n;
	qau_pkg::word_t [3:0] cj;
	qau_pkg::result_t r4n;
	logic [qau_pkg::DataWidth:0] t4;

	assign adv = !v_s4 || !out_stall;
	assign q_stall = !adv;
	assign out_valid = v_s4;
	assign out_res = res_s4;

	assign qa = {q_item.a_z, q_item.a_y, q_item.a_x, q_item.a_s};
	always_comb begin
		qb = {q_item.b_z, q_item.b_y, q_item.b_x, q_item.b_s};
		if (q_item.mode == qau_pkg::MODE_ROTATE) qb[0] = '0;
		qm = (q_item.mode == qau_pkg::MODE_MATRIX) ? qa : qb;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					p_s1[4*i+j] <= qau_pkg::prod_t'(qa[i]) * qau_pkg::prod_t'(qm[j]);
				end
			end
			m_s1 <= q_item.mode;
			a_s1 <= qa;
		end
	end

	// Hamilton sums and matrix sums from products P(i,j) = p_s1[4i+j].
	always_comb begin
		sum2[0] = qau_pkg::sx(p_s1[0]) - qau_pkg::sx(p_s1[5]) - qau_pkg::sx(p_s1[10])
			- qau_pkg::sx(p_s1[15]);
		sum2[1] = qau_pkg::sx(p_s1[1]) + qau_pkg::sx(p_s1[4]) + qau_pkg::sx(p_s1[11])
			- qau_pkg::sx(p_s1[14]);
		sum2[2] = qau_pkg::sx(p_s1[2]) + qau_pkg::sx(p_s1[8]) + qau_pkg::sx(p_s1[13])
			- qau_pkg::sx(p_s1[7]);
		sum2[3] = qau_pkg::sx(p_s1[3]) + qau_pkg::sx(p_s1[12]) + qau_pkg::sx(p_s1[6])
			- qau_pkg::sx(p_s1[9]);
		sum2[4] = '0;
		sum2[5] = '0;
		sum2[6] = '0;
		sum2[7] = '0;
		sum2[8] = '0;
		if (m_s1 == qau_pkg::MODE_MATRIX) begin
			sum2[0] = qau_pkg::sx(p_s1[0]) + qau_pkg::sx(p_s1[5]) - qau_pkg::sx(p_s1[10])
				- qau_pkg::sx(p_s1[15]);
			sum2[1] = (qau_pkg::sx(p_s1[6]) - qau_pkg::sx(p_s1[3])) <<< 1;
			sum2[2] = (qau_pkg::sx(p_s1[7]) + qau_pkg::sx(p_s1[2])) <<< 1;
			sum2[3] = (qau_pkg::sx(p_s1[6]) + qau_pkg::sx(p_s1[3])) <<< 1;
			sum2[4] = qau_pkg::sx(p_s1[0]) + qau_pkg::sx(p_s1[10]) - qau_pkg::sx(p_s1[5])
				- qau_pkg::sx(p_s1[15]);
			sum2[5] = (qau_pkg::sx(p_s1[11]) - qau_pkg::sx(p_s1[1])) <<< 1;
			sum2[6] = (qau_pkg::sx(p_s1[7]) - qau_pkg::sx(p_s1[2])) <<< 1;
			sum2[7] = (qau_pkg::sx(p_s1[11]) + qau_pkg::sx(p_s1[1])) <<< 1;
			sum2[8] = qau_pkg::sx(p_s1[0]) + qau_pkg::sx(p_s1[15]) - qau_pkg::sx(p_s1[5])
				- qau_pkg::sx(p_s1[10]);
		end
		ov2n = 1'b0;
		for (int k = 0; k < 9; k++) begin
			rs = qau_pkg::round_sat(sum2[k]);
			w2n[k] = rs[qau_pkg::DataWidth-1:0];
			ov2n = ov2n | rs[qau_pkg::DataWidth];
		end
		if (m_s1 == qau_pkg::MODE_CONJ) begin
			w2n[0] = a_s1[0];
			ov2n = 1'b0;
			for (int k = 1; k < 4; k++) begin
				if (a_s1[k] == qau_pkg::MinW[qau_pkg::DataWidth-1:0]) begin
					w2n[k] = qau_pkg::MaxW[qau_pkg::DataWidth-1:0];
					ov2n = 1'b1;
				end else begin
					w2n[k] = -a_s1[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s2 <= w2n;
			ov_s2 <= ov2n;
			m_s2 <= m_s1;
			a_s2 <= a_s1;
		end
	end

	always_comb begin
		cj[0] = a_s2[0];
		for (int k = 1; k < 4; k++) cj[k] = -a_s2[k];
	end

	// Products t(i)*c(j); c is the negation of a, taken exactly at product width
	// for the most negative code, the only code where the wrapped negation differs.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					p_s3[4*i+j] <= qau_pkg::prod_t'(w_s2[i])
						* ((j != 0 && a_s2[j] == qau_pkg::MinW[qau_pkg::DataWidth-1:0])
						? -qau_pkg::prod_t'(a_s2[j]) : qau_pkg::prod_t'(cj[j]));
				end
			end
			w_s3 <= w_s2;
			ov_s3 <= ov_s2;
			m_s3 <= m_s2;
		end
	end

	always_comb begin
		sum4[0] = '0;
		sum4[1] = qau_pkg::sx(p_s3[1]) + qau_pkg::sx(p_s3[4]) + qau_pkg::sx(p_s3[11])
			- qau_pkg::sx(p_s3[14]);
		sum4[2] = qau_pkg::sx(p_s3[2]) + qau_pkg::sx(p_s3[8]) + qau_pkg::sx(p_s3[13])
			- qau_pkg::sx(p_s3[7]);
		sum4[3] = qau_pkg::sx(p_s3[3]) + qau_pkg::sx(p_s3[12]) + qau_pkg::sx(p_s3[6])
			- qau_pkg::sx(p_s3[9]);
		t4 = '0;
		r4n.r = w_s3;
		r4n.overflow = ov_s3;
		if (m_s3 == qau_pkg::MODE_ROTATE) begin
			r4n.r = '0;
			for (int k = 1; k < 4; k++) begin
				t4 = qau_pkg::round_sat(sum4[k]);
				r4n.r[k-1] = t4[qau_pkg::DataWidth-1:0];
				r4n.overflow = r4n.overflow | t4[qau_pkg::DataWidth];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s4 <= r4n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && out_stall) |=> (v_s4 && $stable(res_s4)))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s3) |=> v_s4)
		else $error("item lost between stages");
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && m_s3 != qau_pkg::MODE_MATRIX) |-> (w_s3[8:4] == '0))
		else $error("unused result fields not zero");

endmodule

@@ src/quaternion_arithmetic_unit.sv @@
// Each item passes through the queue, then through stages s1 to s4.
// Throughput: one item per cycle while out_stall is low; the four-stage multiplier pipeline sets it.
// A four-entry queue decouples input acceptance from the pipeline stalls.
// Reset: arst_n clears the queue pointers and pipeline valids at once.
module quaternion_arithmetic_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] mode,
	input logic signed [qau_pkg::DataWidth-1:0] a_s,
	input logic signed [qau_pkg::DataWidth-1:0] a_x,
	input logic signed [qau_pkg::DataWidth-1:0] a_y,
	input logic signed [qau_pkg::DataWidth-1:0] a_z,
	input logic signed [qau_pkg::DataWidth-1:0] b_s,
	input logic signed [qau_pkg::DataWidth-1:0] b_x,
	input logic signed [qau_pkg::DataWidth-1:0] b_y,
	input logic signed [qau_pkg::DataWidth-1:0] b_z,
	output logic out_valid,
	input logic out_stall,
	output logic signed [qau_pkg::DataWidth-1:0] r0,
	output logic signed [qau_pkg::DataWidth-1:0] r1,
	output logic signed [qau_pkg::DataWidth-1:0] r2,
	output logic signed [qau_pkg::DataWidth-1:0] r3,
	output logic signed [qau_pkg::DataWidth-1:0] r4,
	output logic signed [qau_pkg::DataWidth-1:0] r5,
	output logic signed [qau_pkg::DataWidth-1:0] r6,
	output logic signed [qau_pkg::DataWidth-1:0] r7,
	output logic signed [qau_pkg::DataWidth-1:0] r8,
	output logic overflow
);

	qau_pkg::item_t in_item, q_item;
	qau_pkg::result_t res;
	logic q_valid, q_stall;

	assign in_item = {qau_pkg::mode_t'(mode), a_s, a_x, a_y, a_z, b_s, b_x, b_y, b_z};

	qau_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .q_valid(q_valid), .q_stall(q_stall), .q_item(q_item)
	);

	qau_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_stall(q_stall),
		.q_item(q_item), .out_valid(out_valid), .out_stall(out_stall), .out_res(res)
	);

	assign r0 = res.r[0];
	assign r1 = res.r[1];
	assign r2 = res.r[2];
	assign r3 = res.r[3];
	assign r4 = res.r[4];
	assign r5 = res.r[5];
	assign r6 = res.r[6];
	assign r7 = res.r[7];
	assign r8 = res.r[8];
	assign overflow = res.overflow;

endmodule
